@@ sv/assert_macros.svh @@
// Assertion macros used by the controller of the cluster chain engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk_i and disabled in reset.
`define CHK_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked on clk_i and disabled in reset.
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ sv/fcce_pkg.sv @@
// Types, constants and codes shared by the cluster chain engine modules.
`default_nettype none

package fcce_pkg;

  localparam int unsigned TABLE_ENTRIES = 4096;
  localparam int unsigned AW            = $clog2(TABLE_ENTRIES);
  localparam int unsigned LIM_W         = AW + 1;
  localparam int unsigned PADDR_W       = 5;

  localparam logic [2:0] ACT_READ  = 3'd0;
  localparam logic [2:0] ACT_WRITE = 3'd1;
  localparam logic [2:0] ACT_MAP   = 3'd2;
  localparam logic [2:0] ACT_ALLOC = 3'd3;
  localparam logic [2:0] ACT_CUT   = 3'd4;
  localparam logic [2:0] ACT_FREE  = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BROKEN = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_BADIDX = 2'd3;

  localparam logic [2:0] REG_FAT12_MODE    = 3'd0;
  localparam logic [2:0] REG_ENTRIES       = 3'd1;
  localparam logic [2:0] REG_CLUSTER_BLKS  = 3'd2;
  localparam logic [2:0] REG_CLUSTER_START = 3'd3;
  localparam logic [2:0] REG_ROOT_START    = 3'd4;

  localparam logic [15:0] END_MARK   = 16'hffff;
  localparam logic [15:0] FREE_STOP  = 16'hfff8;
  localparam logic [15:0] BAD_MASK   = 16'hfff0;
  localparam logic [15:0] WIDEN_BITS = 16'hf000;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] cluster;
    logic [15:0] value;
    logic [15:0] block_index;
    logic        is_root;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] data;
    logic [31:0] disk_block;
  } rsp_t;

  typedef struct packed {
    logic        fat12_mode;
    logic [12:0] entries_in_use;
    logic [7:0]  cluster_blocks;
    logic [31:0] cluster_area_start;
    logic [31:0] root_dir_start;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CLR, OP_RD0, OP_RD1, OP_CAP, OP_WR0, OP_WR1,
    OP_DISPATCH, OP_RD_FIN, OP_MAP_LOOP, OP_MAP_STEP, OP_MAP_FIN,
    OP_AL_UP, OP_AL_UPCHK, OP_AL_DN, OP_AL_DNCHK, OP_AL_SET, OP_AL_LINK,
    OP_CUT_A, OP_FREE_LOOP, OP_FREE_B, OP_DONE
  } dp_op_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_G0, S_G1, S_G2, S_W0, S_W1, S_RD_FIN,
    S_MAP_LOOP, S_MAP_STEP, S_MAP_FIN, S_AL_UP, S_AL_UPCHK, S_AL_DN,
    S_AL_DNCHK, S_AL_SET, S_AL_LINK, S_CUT_A, S_FREE_LOOP, S_FREE_B, S_DONE
  } ctl_state_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       out_free;
    logic [2:0] act;
    logic       cl_valid;
    logic       is_root;
    logic       cl_zero;
    logic       cl_end;
    logic       n_zero;
    logic       link_bad;
    logic       link_zero;
    logic       i_lt_lim;
    logic       i_ge2;
    logic       j_live;
  } st_t;

endpackage

`default_nettype wire

@@ sv/fcce_ctrl.sv @@
// Controller state machine that sequences table accesses for each request.
`default_nettype none
`include "assert_macros.svh"

module fcce_ctrl import fcce_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  st_t  st_i,
  output cmd_t cmd_o
);

  ctl_state_e state_q, state_d;
  ctl_state_e ret_q, ret_d;
  logic       set_q, set_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ret_q   <= S_IDLE;
      set_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      set_q   <= set_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    set_d   = set_q;
    case (state_q)
      S_CLEAR: begin
        if (st_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        state_d = S_DONE;
        case (st_i.act)
          ACT_READ: begin
            if (st_i.cl_valid) begin
              state_d = S_G0; ret_d = S_RD_FIN; set_d = 1'b0;
            end
          end
          ACT_WRITE: begin
            if (st_i.cl_valid) begin
              state_d = S_G0; ret_d = S_DONE; set_d = 1'b1;
            end
          end
          ACT_MAP: begin
            if (!st_i.is_root) state_d = S_MAP_LOOP;
          end
          ACT_ALLOC: state_d = S_AL_UP;
          ACT_CUT: begin
            if (st_i.cl_valid) begin
              state_d = S_G0; ret_d = S_CUT_A; set_d = 1'b0;
            end
          end
          ACT_FREE: begin
            if (!st_i.cl_zero && !st_i.cl_end && st_i.cl_valid) state_d = S_FREE_LOOP;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_G0: state_d = S_G1;
      S_G1: state_d = S_G2;
      S_G2: state_d = set_q ? S_W0 : ret_q;
      S_W0: state_d = S_W1;
      S_W1: state_d = ret_q;
      S_RD_FIN: state_d = S_DONE;
      S_MAP_LOOP: begin
        if (st_i.n_zero) begin
          state_d = S_MAP_FIN;
        end else begin
          state_d = S_G0; ret_d = S_MAP_STEP; set_d = 1'b0;
        end
      end
      S_MAP_STEP: state_d = st_i.link_bad ? S_MAP_FIN : S_MAP_LOOP;
      S_MAP_FIN: state_d = S_DONE;
      S_AL_UP: begin
        if (st_i.i_lt_lim) begin
          state_d = S_G0; ret_d = S_AL_UPCHK; set_d = 1'b0;
        end else begin
          state_d = S_AL_DN;
        end
      end
      S_AL_UPCHK: state_d = st_i.link_zero ? S_AL_SET : S_AL_UP;
      S_AL_DN: begin
        if (st_i.i_ge2) begin
          state_d = S_G0; ret_d = S_AL_DNCHK; set_d = 1'b0;
        end else begin
          state_d = S_DONE;
        end
      end
      S_AL_DNCHK: state_d = st_i.link_zero ? S_AL_SET : S_AL_DN;
      S_AL_SET: begin
        state_d = S_G0; ret_d = S_AL_LINK; set_d = 1'b1;
      end
      S_AL_LINK: begin
        if (st_i.cl_zero) begin
          state_d = S_DONE;
        end else begin
          state_d = S_G0; ret_d = S_DONE; set_d = 1'b1;
        end
      end
      S_CUT_A: begin
        state_d = S_G0; ret_d = S_FREE_LOOP; set_d = 1'b1;
      end
      S_FREE_LOOP: begin
        if (st_i.j_live) begin
          state_d = S_G0; ret_d = S_FREE_B; set_d = 1'b0;
        end else begin
          state_d = S_DONE;
        end
      end
      S_FREE_B: begin
        state_d = S_G0; ret_d = S_FREE_LOOP; set_d = 1'b1;
      end
      S_DONE: begin
        if (st_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    case (state_q)
      S_CLEAR:     cmd_o.op = OP_CLR;
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      S_DISPATCH:  cmd_o.op = OP_DISPATCH;
      S_G0:        cmd_o.op = OP_RD0;
      S_G1:        cmd_o.op = OP_RD1;
      S_G2:        cmd_o.op = OP_CAP;
      S_W0:        cmd_o.op = OP_WR0;
      S_W1:        cmd_o.op = OP_WR1;
      S_RD_FIN:    cmd_o.op = OP_RD_FIN;
      S_MAP_LOOP:  cmd_o.op = OP_MAP_LOOP;
      S_MAP_STEP:  cmd_o.op = OP_MAP_STEP;
      S_MAP_FIN:   cmd_o.op = OP_MAP_FIN;
      S_AL_UP:     cmd_o.op = OP_AL_UP;
      S_AL_UPCHK:  cmd_o.op = OP_AL_UPCHK;
      S_AL_DN:     cmd_o.op = OP_AL_DN;
      S_AL_DNCHK:  cmd_o.op = OP_AL_DNCHK;
      S_AL_SET:    cmd_o.op = OP_AL_SET;
      S_AL_LINK:   cmd_o.op = OP_AL_LINK;
      S_CUT_A:     cmd_o.op = OP_CUT_A;
      S_FREE_LOOP: cmd_o.op = OP_FREE_LOOP;
      S_FREE_B:    cmd_o.op = OP_FREE_B;
      S_DONE:      cmd_o.op = OP_DONE;
      default:     cmd_o.op = OP_NONE;
    endcase
  end

  `CHK_NEXT(a_accept_dispatch, in_valid_i && in_ready_o, state_q == S_DISPATCH)
  `CHK_NEXT(a_read_pair, state_q == S_G0, state_q == S_G1)
  `CHK_NEXT(a_write_pair, state_q == S_W0, state_q == S_W1)
  `CHK_NEXT(a_done_release, state_q == S_DONE && st_i.out_free, state_q == S_IDLE)

endmodule

`default_nettype wire

@@ sv/fcce_dp.sv @@
// Datapath with the link table memory, entry packing and action registers.
`default_nettype none

module fcce_dp import fcce_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  req_t in_req_i,
  input  logic out_ready_i,
  output logic out_valid_o,
  output rsp_t out_rsp_o,
  input  cmd_t cmd_i,
  output st_t  st_o
);

  logic [15:0] mem_q [TABLE_ENTRIES];
  logic [15:0] rdata_q;

  req_t        req_q;
  logic [15:0] ent_q, wv_q, cur_q, n_q, s_q, word0_q, word1_q;
  logic [1:0]  status_q;
  logic [15:0] data_q;
  logic [31:0] disk_q;
  rsp_t        out_rsp_q;
  logic        out_valid_q;
  logic [15:0] hint_q;
  logic        sethint_q;
  logic [AW-1:0] clr_q;

  logic [LIM_W-1:0] lim;
  logic        ent_valid, cl_valid, second_wr, w1_ok, link_bad, out_free;
  logic [AW-1:0] e_a, w_a, mem_addr;
  logic [AW+1:0] tri3;
  logic [AW:0]   w1;
  logic [15:0] link, new0, new1, mem_wdata, s_start, s_m1, down_start;
  logic [11:0] r12, v12;
  logic        mem_we;
  logic [31:0] root_disk, file_disk;

  function automatic logic ent_ok(logic [15:0] e, logic [LIM_W-1:0] l);
    return (e >= 16'd2) && (32'(e) < 32'(l));
  endfunction

  assign lim = (cfg_i.entries_in_use < LIM_W'(TABLE_ENTRIES)) ?
               LIM_W'(cfg_i.entries_in_use) : LIM_W'(TABLE_ENTRIES);
  assign ent_valid = ent_ok(ent_q, lim);
  assign cl_valid  = ent_ok(req_q.cluster, lim);

  assign e_a  = ent_q[AW-1:0];
  assign tri3 = {2'b00, e_a} + {1'b0, e_a, 1'b0};
  assign w_a  = cfg_i.fat12_mode ? tri3[AW+1:2] : e_a;
  assign w1   = {1'b0, w_a} + 1'b1;
  assign w1_ok = !w1[AW];

  always_comb begin
    case (ent_q[1:0])
      2'd0:    r12 = word0_q[11:0];
      2'd1:    r12 = {word1_q[7:0], word0_q[15:12]};
      2'd2:    r12 = {word1_q[3:0], word0_q[15:8]};
      default: r12 = word0_q[15:4];
    endcase
    if (!ent_valid) begin
      link = END_MARK;
    end else if (!cfg_i.fat12_mode) begin
      link = word0_q;
    end else if (r12[11:4] == 8'hff) begin
      link = WIDEN_BITS | {4'h0, r12};
    end else begin
      link = {4'h0, r12};
    end
  end

  assign link_bad = (link == 16'd0) || ((link & BAD_MASK) == BAD_MASK);
  assign v12 = wv_q[11:0];

  always_comb begin
    new1 = word1_q;
    if (!cfg_i.fat12_mode) begin
      new0 = wv_q;
    end else begin
      case (ent_q[1:0])
        2'd0: new0 = {word0_q[15:12], v12};
        2'd1: begin
          new0 = {v12[3:0], word0_q[11:0]};
          new1 = {word1_q[15:8], v12[11:4]};
        end
        2'd2: begin
          new0 = {v12[7:0], word0_q[7:0]};
          new1 = {word1_q[15:4], v12[11:8]};
        end
        default: new0 = {v12, word0_q[3:0]};
      endcase
    end
  end

  assign second_wr = cfg_i.fat12_mode && (ent_q[1:0] inside {2'd1, 2'd2}) && w1_ok;

  always_comb begin
    mem_addr  = w_a;
    mem_we    = 1'b0;
    mem_wdata = new0;
    case (cmd_i.op)
      OP_CLR: begin
        mem_addr  = clr_q;
        mem_we    = 1'b1;
        mem_wdata = 16'd0;
      end
      OP_RD1: mem_addr = w1[AW-1:0];
      OP_WR0: mem_we = ent_valid;
      OP_WR1: begin
        mem_addr  = w1[AW-1:0];
        mem_we    = ent_valid && second_wr;
        mem_wdata = new1;
      end
      default: mem_addr = w_a;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    rdata_q <= mem_q[mem_addr];
  end

  assign s_start = (req_q.cluster != 16'd0) ? req_q.cluster : hint_q;
  assign s_m1    = s_q - 16'd1;
  always_comb begin
    if (lim == '0) begin
      down_start = 16'd0;
    end else if (32'(s_m1) < 32'(lim)) begin
      down_start = s_m1;
    end else begin
      down_start = 16'(lim - 1'b1);
    end
  end

  assign root_disk = cfg_i.root_dir_start +
                     ({16'd0, req_q.block_index} * {24'd0, cfg_i.cluster_blocks});
  assign file_disk = 32'(({16'd0, cur_q} - 32'd2) * {24'd0, cfg_i.cluster_blocks})
                     + cfg_i.cluster_area_start;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hint_q      <= 16'd2;
      sethint_q   <= 1'b0;
      clr_q       <= '0;
    end else begin
      if (cmd_i.op == OP_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_CLR: clr_q <= clr_q + 1'b1;
        OP_DISPATCH: begin
          if (req_q.action == ACT_FREE) sethint_q <= 1'b0;
        end
        OP_AL_SET: hint_q <= cur_q + 16'd1;
        OP_CUT_A: sethint_q <= 1'b1;
        OP_FREE_B: begin
          if (sethint_q && ent_valid) begin
            hint_q    <= ent_q;
            sethint_q <= 1'b0;
          end
        end
        default: sethint_q <= sethint_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        req_q    <= in_req_i;
        status_q <= ST_OK;
        data_q   <= 16'd0;
        disk_q   <= 32'd0;
      end
      OP_DISPATCH: begin
        case (req_q.action)
          ACT_READ, ACT_WRITE, ACT_CUT: begin
            ent_q <= req_q.cluster;
            wv_q  <= req_q.value;
            if (!cl_valid) begin
              status_q <= ST_BADIDX;
              if (req_q.action == ACT_READ) data_q <= END_MARK;
            end
          end
          ACT_MAP: begin
            if (req_q.is_root) disk_q <= root_disk;
            cur_q <= req_q.cluster;
            n_q   <= req_q.block_index;
          end
          ACT_ALLOC: begin
            cur_q <= (s_start < 16'd2) ? 16'd2 : s_start;
            s_q   <= (s_start < 16'd2) ? 16'd2 : s_start;
          end
          ACT_FREE: begin
            cur_q <= req_q.cluster;
            if (req_q.cluster != 16'd0 && req_q.cluster < FREE_STOP && !cl_valid) begin
              status_q <= ST_BADIDX;
            end
          end
          default: status_q <= ST_BADIDX;
        endcase
      end
      OP_RD1: word0_q <= rdata_q;
      OP_CAP: word1_q <= w1_ok ? rdata_q : 16'd0;
      OP_RD_FIN: data_q <= link;
      OP_MAP_LOOP: ent_q <= cur_q;
      OP_MAP_STEP: begin
        cur_q <= link;
        n_q   <= n_q - 16'd1;
        if (link_bad) status_q <= ST_BROKEN;
      end
      OP_MAP_FIN: begin
        data_q <= cur_q;
        disk_q <= (status_q == ST_BROKEN) ? 32'hffff_ffff : file_disk;
      end
      OP_AL_UP: begin
        if (32'(cur_q) < 32'(lim)) ent_q <= cur_q;
        else cur_q <= down_start;
      end
      OP_AL_UPCHK: begin
        if (link != 16'd0) cur_q <= cur_q + 16'd1;
      end
      OP_AL_DN: begin
        ent_q <= cur_q;
        if (cur_q < 16'd2) begin
          status_q <= ST_FULL;
          data_q   <= END_MARK;
        end
      end
      OP_AL_DNCHK: begin
        if (link != 16'd0) cur_q <= cur_q - 16'd1;
      end
      OP_AL_SET: begin
        ent_q  <= cur_q;
        wv_q   <= END_MARK;
        data_q <= cur_q;
      end
      OP_AL_LINK: begin
        ent_q <= req_q.cluster;
        wv_q  <= cur_q;
      end
      OP_CUT_A: begin
        cur_q <= link;
        ent_q <= req_q.cluster;
        wv_q  <= END_MARK;
      end
      OP_FREE_LOOP: ent_q <= cur_q;
      OP_FREE_B: begin
        cur_q <= link;
        wv_q  <= 16'd0;
      end
      OP_DONE: begin
        if (out_free) out_rsp_q <= '{status: status_q, data: data_q, disk_block: disk_q};
      end
      default: ent_q <= ent_q;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  always_comb begin
    st_o.clr_done  = (clr_q == {AW{1'b1}});
    st_o.out_free  = out_free;
    st_o.act       = req_q.action;
    st_o.cl_valid  = cl_valid;
    st_o.is_root   = req_q.is_root;
    st_o.cl_zero   = (req_q.cluster == 16'd0);
    st_o.cl_end    = (req_q.cluster >= FREE_STOP);
    st_o.n_zero    = (n_q == 16'd0);
    st_o.link_bad  = link_bad;
    st_o.link_zero = (link == 16'd0);
    st_o.i_lt_lim  = (32'(cur_q) < 32'(lim));
    st_o.i_ge2     = (cur_q >= 16'd2);
    st_o.j_live    = (cur_q != 16'd0) && (cur_q < FREE_STOP);
  end

endmodule

`default_nettype wire

@@ sv/fat_cluster_chain_engine.sv @@
// Top level of the cluster chain engine: register port, controller and datapath.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_ready_o  in_req_i (req_t)
//   out      output     out_valid_o/out_ready_i out_rsp_o (rsp_t)
//   cfg      input      psel/penable/pwrite    paddr, pwdata, prdata
//
// After reset the table is cleared one entry per cycle, before the first request.
// Each table access uses the port of a single memory; a link read runs through S_G0, S_G1, S_G2.
// A finished result waits in an output register; the next request is taken meanwhile.
`default_nettype none

module fat_cluster_chain_engine import fcce_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  req_t               in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rsp_t               out_rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t       cfg_q;
  cmd_t       cmd;
  st_t        st;
  logic [2:0] reg_idx;

  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fat12_mode         <= 1'b0;
      cfg_q.entries_in_use     <= 13'd4096;
      cfg_q.cluster_blocks     <= 8'd1;
      cfg_q.cluster_area_start <= 32'd0;
      cfg_q.root_dir_start     <= 32'd0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_FAT12_MODE:    cfg_q.fat12_mode         <= pwdata[0];
        REG_ENTRIES:       cfg_q.entries_in_use     <= pwdata[12:0];
        REG_CLUSTER_BLKS:  cfg_q.cluster_blocks     <= pwdata[7:0];
        REG_CLUSTER_START: cfg_q.cluster_area_start <= pwdata;
        REG_ROOT_START:    cfg_q.root_dir_start     <= pwdata;
        default:           cfg_q <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FAT12_MODE:    prdata = {31'd0, cfg_q.fat12_mode};
      REG_ENTRIES:       prdata = {19'd0, cfg_q.entries_in_use};
      REG_CLUSTER_BLKS:  prdata = {24'd0, cfg_q.cluster_blocks};
      REG_CLUSTER_START: prdata = cfg_q.cluster_area_start;
      REG_ROOT_START:    prdata = cfg_q.root_dir_start;
      default:           prdata = 32'd0;
    endcase
  end

  fcce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  fcce_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_req_i    (in_req_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o),
    .cmd_i       (cmd),
    .st_o        (st)
  );

endmodule

`default_nettype wire

@@ verif/tb_fat_cluster_chain_engine.sv @@
// Self-checking testbench for the cluster chain engine with a built-in table predictor.
`default_nettype none

module tb_fat_cluster_chain_engine;
  import fcce_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  req_t               in_req_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  rsp_t               out_rsp_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  fat_cluster_chain_engine dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state.
  logic [15:0] fat_words [TABLE_ENTRIES];
  logic [15:0] next_free;
  logic        m_fat12;
  logic [12:0] m_entries;
  logic [7:0]  m_cblocks;
  logic [31:0] m_area;
  logic [31:0] m_root;

  rsp_t        pending_rsp [$];
  int          mismatches = 0;
  bit          quiet = 1'b0;
  int          stall_left = 0;

  // Chain bookkeeping for well-formed request sequences.
  int unsigned chain_head = 0;
  int unsigned chain_tail = 0;
  int unsigned chain_len = 0;

  function automatic int unsigned usable_entries();
    return (m_entries < TABLE_ENTRIES) ? m_entries : TABLE_ENTRIES;
  endfunction

  function automatic bit index_ok(int unsigned e);
    return e >= 2 && e < usable_entries();
  endfunction

  function automatic logic [15:0] word_at(int unsigned w);
    return (w < TABLE_ENTRIES) ? fat_words[w] : 16'h0;
  endfunction

  function automatic void word_put(int unsigned w, logic [15:0] v);
    if (w < TABLE_ENTRIES) fat_words[w] = v;
  endfunction

  function automatic logic [15:0] link_of(int unsigned e);
    int unsigned w;
    logic [31:0] r;
    if (!index_ok(e)) return END_MARK;
    if (!m_fat12) return fat_words[e];
    w = (e * 3) / 4;
    case (e % 4)
      0: r = word_at(w);
      1: r = (32'(word_at(w)) >> 12) | (32'(word_at(w + 1)) << 4);
      2: r = (32'(word_at(w)) >> 8) | (32'(word_at(w + 1)) << 8);
      default: r = 32'(word_at(w)) >> 4;
    endcase
    r = r & 32'hfff;
    if ((r & 32'hff0) == 32'hff0) r = r | 32'(WIDEN_BITS);
    return r[15:0];
  endfunction

  function automatic void set_link(int unsigned e, logic [15:0] v);
    int unsigned w;
    logic [15:0] v12;
    if (!index_ok(e)) return;
    if (!m_fat12) begin
      fat_words[e] = v;
      return;
    end
    v12 = v & 16'h0fff;
    w = (e * 3) / 4;
    case (e % 4)
      0: word_put(w, (word_at(w) & 16'hf000) | v12);
      1: begin
        word_put(w, (word_at(w) & 16'h0fff) | (v12 << 12));
        word_put(w + 1, (word_at(w + 1) & 16'hff00) | (v12 >> 4));
      end
      2: begin
        word_put(w, (word_at(w) & 16'h00ff) | (v12 << 8));
        word_put(w + 1, (word_at(w + 1) & 16'hfff0) | (v12 >> 8));
      end
      default: word_put(w, (word_at(w) & 16'h000f) | (v12 << 4));
    endcase
  endfunction

  function automatic void release_chain(int unsigned j, bit move_hint);
    int unsigned nxt;
    while (j != 0 && j < FREE_STOP) begin
      nxt = link_of(j);
      if (move_hint && index_ok(j)) begin
        next_free = j[15:0];
        move_hint = 1'b0;
      end
      set_link(j, 16'h0);
      j = nxt;
    end
  endfunction

  function automatic rsp_t chain_result(req_t r);
    rsp_t o;
    int unsigned cl, cur, s, lim, n;
    int i;
    bit found;
    o = '0;
    cl = r.cluster;
    case (r.action)
      ACT_READ: begin
        if (index_ok(cl)) o.data = link_of(cl);
        else begin
          o.status = ST_BADIDX;
          o.data = END_MARK;
        end
      end
      ACT_WRITE: begin
        if (index_ok(cl)) set_link(cl, r.value);
        else o.status = ST_BADIDX;
      end
      ACT_MAP: begin
        if (r.is_root) o.disk_block = m_root + 32'(r.block_index) * 32'(m_cblocks);
        else begin
          cur = cl;
          for (n = r.block_index; n > 0; n--) begin
            cur = link_of(cur);
            if (cur == 0 || (cur & BAD_MASK) == BAD_MASK) begin
              o.status = ST_BROKEN;
              break;
            end
          end
          o.data = cur[15:0];
          if (o.status == ST_BROKEN) o.disk_block = 32'hffffffff;
          else o.disk_block = (32'(cur) - 32'd2) * 32'(m_cblocks) + m_area;
        end
      end
      ACT_ALLOC: begin
        s = (cl != 0) ? cl : next_free;
        if (s < 2) s = 2;
        lim = usable_entries();
        found = 1'b0;
        for (i = s; i < lim; i++)
          if (link_of(i) == 0) begin
            found = 1'b1;
            break;
          end
        if (!found) begin
          i = (s - 1 < lim) ? s - 1 : lim - 1;
          for (; i >= 2; i--)
            if (link_of(i) == 0) begin
              found = 1'b1;
              break;
            end
        end
        if (!found) begin
          o.status = ST_FULL;
          o.data = END_MARK;
        end else begin
          set_link(i, END_MARK);
          next_free = 16'(i + 1);
          if (cl != 0) set_link(cl, 16'(i));
          o.data = 16'(i);
        end
      end
      ACT_CUT: begin
        if (!index_ok(cl)) o.status = ST_BADIDX;
        else begin
          n = link_of(cl);
          set_link(cl, END_MARK);
          release_chain(n, 1'b1);
        end
      end
      ACT_FREE: begin
        if (cl != 0 && cl < FREE_STOP) begin
          if (!index_ok(cl)) o.status = ST_BADIDX;
          else release_chain(cl, 1'b0);
        end
      end
      default: o.status = ST_BADIDX;
    endcase
    return o;
  endfunction

  function automatic int gap_len();
    int p;
    if (quiet) return 0;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      stall_left <= gap_len();
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", out_rsp_o);
      end else begin
        want = pending_rsp.pop_front();
        if (out_rsp_o.status !== want.status || out_rsp_o.data !== want.data ||
            out_rsp_o.disk_block !== want.disk_block) begin
          mismatches++;
          if (mismatches <= 10)
            $display("response mismatch: expected %p, got %p", want, out_rsp_o);
        end
      end
    end
  end

  task automatic send_request(req_t r, bit typed, rsp_t typed_rsp);
    rsp_t p;
    int g;
    in_valid_i <= 1'b1;
    in_req_i <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    p = chain_result(r);
    pending_rsp.push_back(typed ? typed_rsp : p);
    if (r.action == ACT_ALLOC && p.status == ST_OK) begin
      if (r.cluster == 0 || r.cluster != chain_tail) begin
        chain_head = p.data;
        chain_len = 1;
      end else chain_len++;
      chain_tail = p.data;
    end
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FAT12_MODE:    m_fat12 = v[0];
      REG_ENTRIES:       m_entries = v[12:0];
      REG_CLUSTER_BLKS:  m_cblocks = v[7:0];
      REG_CLUSTER_START: m_area = v;
      default:           m_root = v;
    endcase
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_cluster(int unsigned lim);
    int p;
    p = $urandom_range(99);
    if (p < 80) return 16'($urandom_range(lim + 1, 0));
    if (p < 92) return 16'($urandom);
    return 16'($urandom_range(16'hffff, 16'hfff8));
  endfunction

  function automatic req_t random_request(int unsigned lim);
    req_t r;
    int p;
    r = '0;
    r.is_root = $urandom_range(1);
    r.block_index = 16'($urandom_range(8));
    r.cluster = pick_cluster(lim);
    p = $urandom_range(99);
    case (p % 4)
      0: r.value = 16'($urandom_range(lim + 1, 0));
      1: r.value = 16'h0;
      2: r.value = $urandom_range(1) ? 16'($urandom_range(16'hffff, 16'hfff0))
                                     : 16'($urandom_range(12'hfff, 12'hff0));
      default: r.value = 16'($urandom);
    endcase
    p = $urandom_range(99);
    if (p < 15) r.action = ACT_READ;
    else if (p < 28) r.action = ACT_WRITE;
    else if (p < 50) begin
      r.action = ACT_MAP;
      if (r.is_root) r.block_index = 16'($urandom);
      else if (chain_len > 0 && $urandom_range(3) != 0) begin
        r.cluster = 16'(chain_head);
        r.block_index = 16'($urandom_range(chain_len));
      end else if ($urandom_range(4) == 0) r.block_index = 16'($urandom_range(2 * lim));
    end else if (p < 78) begin
      r.action = ACT_ALLOC;
      case ($urandom_range(3))
        0: r.cluster = 16'h0;
        1, 2: r.cluster = 16'(chain_tail);
        default: ;
      endcase
    end else if (p < 87) begin
      r.action = ACT_CUT;
      if (chain_len > 0 && $urandom_range(1)) r.cluster = 16'(chain_head);
    end else if (p < 96) begin
      r.action = ACT_FREE;
      if (chain_len > 0 && $urandom_range(1)) begin
        r.cluster = 16'(chain_head);
        chain_len = 0;
      end
    end else r.action = 3'($urandom_range(7, 6));
    return r;
  endfunction

  typedef struct {
    req_t rq;
    bit   typed;
    rsp_t rs;
  } step_row_t;

  function automatic step_row_t mk(logic [2:0] a, logic [15:0] c, logic [15:0] v,
                                   logic [15:0] b, logic rt, bit typed,
                                   logic [1:0] st, logic [15:0] d, logic [31:0] db);
    step_row_t s;
    s.rq = '{action: a, cluster: c, value: v, block_index: b, is_root: rt};
    s.typed = typed;
    s.rs = '{status: st, data: d, disk_block: db};
    return s;
  endfunction

  initial begin
    step_row_t dir_rows [$];
    static int unsigned entry_sets [14] = '{4096, 2, 3, 16, 40, 64, 100, 300, 4096, 17, 32,
                                            64, 8, 50};
    int unsigned lim;
    int n_items;
    logic [31:0] cb;

    for (int k = 0; k < TABLE_ENTRIES; k++) fat_words[k] = 16'h0;
    next_free = 16'd2;
    m_fat12 = 1'b0;
    m_entries = 13'd4096;
    m_cblocks = 8'd1;
    m_area = 32'h0;
    m_root = 32'h0;

    dir_rows.push_back(mk(ACT_READ, 16'd2, 16'h0, 16'h0, 1'b0, 1, ST_OK, 16'h0, 32'h0));
    dir_rows.push_back(mk(ACT_READ, 16'd0, 16'h0, 16'h0, 1'b0, 1, ST_BADIDX, END_MARK, 32'h0));
    dir_rows.push_back(mk(ACT_READ, 16'hffff, 16'h0, 16'h0, 1'b0, 1, ST_BADIDX, END_MARK, 32'h0));
    dir_rows.push_back(mk(ACT_WRITE, 16'd1, 16'h1234, 16'h0, 1'b0, 1, ST_BADIDX, 16'h0, 32'h0));
    dir_rows.push_back(mk(3'd6, 16'd5, 16'h0, 16'h0, 1'b0, 1, ST_BADIDX, 16'h0, 32'h0));
    dir_rows.push_back(mk(3'd7, 16'd5, 16'h0, 16'h0, 1'b0, 1, ST_BADIDX, 16'h0, 32'h0));
    dir_rows.push_back(mk(ACT_MAP, 16'h0, 16'h0, 16'hffff, 1'b1, 1, ST_OK, 16'h0, 32'h0000ffff));
    dir_rows.push_back(mk(ACT_ALLOC, 16'd0, 16'h0, 16'h0, 1'b0, 1, ST_OK, 16'd2, 32'h0));
    dir_rows.push_back(mk(ACT_ALLOC, 16'd2, 16'h0, 16'h0, 1'b0, 0, ST_OK, 16'h0, 32'h0));
    dir_rows.push_back(mk(ACT_MAP, 16'd2, 16'h0, 16'd1, 1'b0, 0, ST_OK, 16'h0, 32'h0));
    dir_rows.push_back(mk(ACT_MAP, 16'd2, 16'h0, 16'hffff, 1'b0, 0, ST_OK, 16'h0, 32'h0));
    dir_rows.push_back(mk(ACT_MAP, 16'd0, 16'h0, 16'd0, 1'b0, 0, ST_OK, 16'h0, 32'h0));
    dir_rows.push_back(mk(ACT_WRITE, 16'd4095, 16'hffff, 16'h0, 1'b0, 0, ST_OK, 16'h0, 32'h0));
    dir_rows.push_back(mk(ACT_READ, 16'd4095, 16'h0, 16'h0, 1'b0, 0, ST_OK, 16'h0, 32'h0));
    dir_rows.push_back(mk(ACT_WRITE, 16'd4, 16'h0005, 16'h0, 1'b0, 0, ST_OK, 16'h0, 32'h0));
    dir_rows.push_back(mk(ACT_WRITE, 16'd5, 16'hfff7, 16'h0, 1'b0, 0, ST_OK, 16'h0, 32'h0));
    dir_rows.push_back(mk(ACT_MAP, 16'd4, 16'h0, 16'd2, 1'b0, 0, ST_OK, 16'h0, 32'h0));
    dir_rows.push_back(mk(ACT_CUT, 16'd0, 16'h0, 16'h0, 1'b0, 1, ST_BADIDX, 16'h0, 32'h0));
    dir_rows.push_back(mk(ACT_CUT, 16'd2, 16'h0, 16'h0, 1'b0, 0, ST_OK, 16'h0, 32'h0));
    dir_rows.push_back(mk(ACT_FREE, 16'd0, 16'h0, 16'h0, 1'b0, 1, ST_OK, 16'h0, 32'h0));
    dir_rows.push_back(mk(ACT_FREE, FREE_STOP, 16'h0, 16'h0, 1'b0, 1, ST_OK, 16'h0, 32'h0));
    dir_rows.push_back(mk(ACT_FREE, 16'd1, 16'h0, 16'h0, 1'b0, 1, ST_BADIDX, 16'h0, 32'h0));
    dir_rows.push_back(mk(ACT_FREE, 16'd4, 16'h0, 16'h0, 1'b0, 0, ST_OK, 16'h0, 32'h0));
    dir_rows.push_back(mk(ACT_ALLOC, 16'd0, 16'h0, 16'h0, 1'b0, 0, ST_OK, 16'h0, 32'h0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[k]) send_request(dir_rows[k].rq, dir_rows[k].typed, dir_rows[k].rs);
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      case (ph % 3)
        0: cb = 32'd1;
        1: cb = 32'd128;
        default: cb = $urandom_range(127, 2);
      endcase
      write_reg(REG_FAT12_MODE, 32'(ph % 2));
      write_reg(REG_ENTRIES, entry_sets[ph]);
      write_reg(REG_CLUSTER_BLKS, cb);
      write_reg(REG_CLUSTER_START, (ph % 4 == 1) ? 32'hffffffff : (ph % 4 == 2) ? 32'h0 : $urandom);
      write_reg(REG_ROOT_START, (ph % 4 == 3) ? 32'hffffffff : (ph % 4 == 0) ? 32'h0 : $urandom);
      chain_len = 0;
      chain_tail = 0;
      lim = usable_entries();
      quiet = (ph % 5 == 2);
      n_items = (lim >= 1000) ? 60 : 150;
      for (int k = 0; k < n_items; k++) begin
        send_request(random_request(lim), 1'b0, '0);
        if (k == n_items / 2 && ph % 4 == 0) begin
          in_valid_i <= 1'b0;
          while (pending_rsp.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #(20 * 4000000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+sv
sv/fcce_pkg.sv
sv/fcce_ctrl.sv
sv/fcce_dp.sv
sv/fat_cluster_chain_engine.sv
verif/tb_fat_cluster_chain_engine.sv
